// ===== sv/vse_pkg.sv =====
package vse_pkg;

   localparam int VSE_DEPTH      = 256;
   localparam int VSE_WORD_WIDTH = 64;

   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 64;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 9;
   localparam int SLOT_W   = 9;
   localparam int STATUS_W = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH    = 3'd0,
      MODE_POP     = 3'd1,
      MODE_POP_SEC = 3'd2,
      MODE_POP_N   = 3'd3,
      MODE_RESERVE = 3'd4,
      MODE_READ    = 3'd5,
      MODE_WRITE   = 3'd6,
      MODE_SET_PTR = 3'd7
   } mode_type;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BOUNDS    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADPTR    = 3'd4;

   typedef struct packed {
      logic clr_wr;
      logic capture;
      logic rd_first;
      logic rd_second;
      logic hold_top;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic err;
      logic two_rd;
      logic out_free;
   } dp_status_type;

endpackage

// ===== sv/vse_ram.sv =====
module vse_ram
   #(
      parameter int WIDTH = 64,
      parameter int DEPTH = 256
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic                     rd_en,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/vse_ctrl.sv =====
module vse_ctrl
   import vse_pkg::*;
   (
      input  logic          clock,
      input  logic          reset,
      input  logic          req_valid,
      output logic          req_ready,
      input  dp_status_type st,
      output ctl_cmd_type   cmd
   );

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_RD1,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         req_ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               if (st.clr_last) begin
                  state_ff     <= S_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  state_ff     <= S_EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (!st.err && st.two_rd) begin
                  state_ff <= S_RD1;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_RD1: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (st.out_free) begin
                  state_ff     <= S_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= S_CLEAR;
               req_ready_ff <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.clr_wr    = (state_ff == S_CLEAR);
      cmd.capture   = (state_ff == S_IDLE) && req_valid;
      cmd.rd_first  = (state_ff == S_EXEC) && !st.err;
      cmd.rd_second = (state_ff == S_RD1);
      cmd.hold_top  = (state_ff == S_RD1);
      cmd.commit    = (state_ff == S_DONE) && st.out_free;
   end

   assign req_ready = req_ready_ff;

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready_ff == (state_ff == S_IDLE))
      else $error("req_ready out of step with the idle state");

endmodule

// ===== sv/vse_dp.sv =====
module vse_dp
   import vse_pkg::*;
   #(
      parameter int DEPTH      = VSE_DEPTH,
      parameter int WORD_WIDTH = VSE_WORD_WIDTH
   )
   (
      input  logic                       clock,
      input  logic                       reset,
      input  ctl_cmd_type                cmd,
      output dp_status_type              st,
      input  logic [MODE_W-1:0]          req_mode,
      input  logic [VALUE_W-1:0]         req_value,
      input  logic signed [INDEX_W-1:0]  req_index,
      input  logic [COUNT_W-1:0]         req_count,
      output logic                       rsp_valid,
      input  logic                       rsp_ready,
      output logic [VALUE_W-1:0]         rsp_data,
      output logic [SLOT_W-1:0]          rsp_slot,
      output logic [SLOT_W-1:0]          rsp_depth_now,
      output logic [STATUS_W-1:0]        rsp_status
   );

   localparam int AW = $clog2(DEPTH);
   localparam int PW = $clog2(DEPTH + 1);
   localparam int EW = ((PW > INDEX_W) ? PW : INDEX_W) + 1;

   mode_type                    mode_ff;
   logic [WORD_WIDTH-1:0]       value_ff;
   logic signed [INDEX_W-1:0]   index_ff;
   logic [COUNT_W-1:0]          count_ff;
   logic [PW-1:0]               sp_ff;
   logic [AW-1:0]               clr_cnt_ff;
   logic [WORD_WIDTH-1:0]       hold_ff;
   logic                        rsp_valid_ff;
   logic [VALUE_W-1:0]          rsp_data_ff;
   logic [SLOT_W-1:0]           rsp_slot_ff;
   logic [SLOT_W-1:0]           rsp_depth_ff;
   logic [STATUS_W-1:0]         rsp_status_ff;

   logic [EW-1:0]               sp_x;
   logic [EW-1:0]               cnt_x;
   logic [EW-1:0]               dep_x;
   logic signed [EW:0]          idx_s;
   logic signed [EW:0]          eff_s;
   logic                        in_bounds;
   logic [PW-1:0]               sp_m1;
   logic [PW-1:0]               sp_m2;
   logic [AW-1:0]               eff_addr;
   logic [STATUS_W-1:0]         status;
   logic                        err;
   logic [PW-1:0]               sp_in;
   logic                        mem_wr_op;
   logic                        rd_op;
   logic [AW-1:0]               op_wr_addr;
   logic [AW-1:0]               op_rd_addr;
   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [WORD_WIDTH-1:0]       ram_wr_data;
   logic                        ram_rd_en;
   logic [AW-1:0]               ram_rd_addr;
   logic [WORD_WIDTH-1:0]       ram_rd_data;

   assign sp_x  = EW'(sp_ff);
   assign cnt_x = EW'(count_ff);
   assign dep_x = EW'(DEPTH);
   assign idx_s = (EW + 1)'(index_ff);
   assign eff_s = index_ff[INDEX_W-1] ? (idx_s + $signed({1'b0, sp_x})) : idx_s;
   assign in_bounds = !eff_s[EW] && (eff_s[EW-1:0] < sp_x);
   assign sp_m1    = sp_ff - PW'(1);
   assign sp_m2    = sp_ff - PW'(2);
   assign eff_addr = AW'(eff_s[EW-1:0]);

   always_comb begin
      status     = ST_OK;
      sp_in      = sp_ff;
      mem_wr_op  = 1'b0;
      rd_op      = 1'b0;
      op_wr_addr = AW'(sp_ff);
      op_rd_addr = AW'(sp_m1);
      case (mode_ff)
         MODE_PUSH: begin
            if (sp_x >= dep_x) begin
               status = ST_OVERFLOW;
            end else begin
               sp_in     = sp_ff + PW'(1);
               mem_wr_op = 1'b1;
            end
         end
         MODE_POP: begin
            rd_op = 1'b1;
            if (sp_ff == '0) begin
               status = ST_UNDERFLOW;
            end else begin
               sp_in = sp_m1;
            end
         end
         MODE_POP_SEC: begin
            rd_op      = 1'b1;
            op_wr_addr = AW'(sp_m2);
            if (sp_x < EW'(2)) begin
               status = ST_UNDERFLOW;
            end else begin
               sp_in     = sp_m1;
               mem_wr_op = 1'b1;
            end
         end
         MODE_POP_N: begin
            rd_op = 1'b1;
            if ((sp_ff == '0) || (cnt_x > sp_x)) begin
               status = ST_UNDERFLOW;
            end else begin
               sp_in = PW'(sp_x - cnt_x);
            end
         end
         MODE_RESERVE: begin
            if ((sp_x + cnt_x) > dep_x) begin
               status = ST_OVERFLOW;
            end else begin
               sp_in = PW'(sp_x + cnt_x);
            end
         end
         MODE_READ: begin
            rd_op      = 1'b1;
            op_rd_addr = eff_addr;
            if (!in_bounds) begin
               status = ST_BOUNDS;
            end
         end
         MODE_WRITE: begin
            op_wr_addr = eff_addr;
            if (!in_bounds) begin
               status = ST_BOUNDS;
            end else begin
               mem_wr_op = 1'b1;
            end
         end
         MODE_SET_PTR: begin
            if ((count_ff == '0) || (cnt_x > dep_x)) begin
               status = ST_BADPTR;
            end else begin
               sp_in = PW'(cnt_x);
            end
         end
         default: begin
            status = ST_BADPTR;
         end
      endcase
   end

   assign err = (status != ST_OK);

   always_comb begin
      if (cmd.clr_wr) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = cmd.commit && mem_wr_op;
         ram_wr_addr = op_wr_addr;
         ram_wr_data = (mode_ff == MODE_POP_SEC) ? hold_ff : value_ff;
      end
   end

   assign ram_rd_en   = (cmd.rd_first && rd_op) || cmd.rd_second;
   assign ram_rd_addr = cmd.rd_second ? AW'(sp_m2) : op_rd_addr;

   vse_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= req_value[WORD_WIDTH-1:0];
         index_ff <= req_index;
         count_ff <= req_count;
      end
      if (cmd.hold_top) begin
         hold_ff <= ram_rd_data;
      end
      if (cmd.commit) begin
         rsp_data_ff   <= (rd_op && !err) ? VALUE_W'(ram_rd_data) : '0;
         rsp_slot_ff   <= (!err && (mode_ff inside {MODE_PUSH, MODE_RESERVE}))
                          ? SLOT_W'(sp_ff) : '0;
         rsp_depth_ff  <= SLOT_W'(sp_in);
         rsp_status_ff <= status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_wr) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (cmd.commit) begin
            sp_ff <= sp_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      st          = '0;
      st.clr_last = (clr_cnt_ff == AW'(DEPTH - 1));
      st.err      = err;
      st.two_rd   = (mode_ff == MODE_POP_SEC);
      st.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_depth_now = rsp_depth_ff;
   assign rsp_status    = rsp_status_ff;

   a_sp_bounded: assert property (@(posedge clock) disable iff (reset)
      sp_x <= dep_x)
      else $error("stack pointer beyond the store depth");

   a_fail_keeps_sp: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && err) |=> $stable(sp_ff))
      else $error("failed operation changed the stack pointer");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

endmodule

// ===== sv/value_stack_engine.sv =====
// Channel  Direction  Handshake              Payload
// req_     in         req_valid, req_ready   mode, value, index, count
// rsp_     out        rsp_valid, rsp_ready   data, slot, depth_now, status
//
// An operation is captured on transfer, reads the store if needed and then
// commits; pop-second adds a second read because it reads two words through
// the single store read port. req_ready rises again in the cycle after a
// result is committed. After reset every store word is zeroed while
// req_ready is low. A result waits in the output register; a following
// operation stalls only at commit while that register is full and unread.
module value_stack_engine
   import vse_pkg::*;
   #(
      parameter int DEPTH      = VSE_DEPTH,
      parameter int WORD_WIDTH = VSE_WORD_WIDTH
   )
   (
      input  logic                      clock,
      input  logic                      reset,
      input  logic                      req_valid,
      output logic                      req_ready,
      input  logic [MODE_W-1:0]         req_mode,
      input  logic [VALUE_W-1:0]        req_value,
      input  logic signed [INDEX_W-1:0] req_index,
      input  logic [COUNT_W-1:0]        req_count,
      output logic                      rsp_valid,
      input  logic                      rsp_ready,
      output logic [VALUE_W-1:0]        rsp_data,
      output logic [SLOT_W-1:0]         rsp_slot,
      output logic [SLOT_W-1:0]         rsp_depth_now,
      output logic [STATUS_W-1:0]       rsp_status
   );

   ctl_cmd_type   cmd;
   dp_status_type st;

   vse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   vse_dp #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .req_index     (req_index),
      .req_count     (req_count),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .rsp_slot      (rsp_slot),
      .rsp_depth_now (rsp_depth_now),
      .rsp_status    (rsp_status)
   );

endmodule
